// ----- rtl/tksel_pkg.sv -----
package tksel_pkg;

  // Store geometry
  localparam int STORE_DEPTH = 16;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  // Field widths
  localparam int ID_W    = 32;
  localparam int VAL_W   = 64;
  localparam int KEEP_W  = 5;
  localparam int ENTRY_W = ID_W + VAL_W;
  localparam int CAP_W   = (KEEP_W > CNT_W) ? KEEP_W : CNT_W;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = KEEP_W;
  localparam logic [CFG_IDX_W-1:0] CFG_ASCENDING  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT = 1'd1;

  // Item kinds
  localparam logic KIND_CAND = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [ID_W-1:0]         doc_id;
    logic signed [VAL_W-1:0] sort_value;
    logic                    live;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]         out_doc_id;
    logic signed [VAL_W-1:0] out_value;
    logic                    valid_res;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [VAL_W-1:0] val;
  } entry_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic accept;    // capture input transaction
    logic set_pos;   // pos <= entry count
    logic inc_cnt;   // entry count + 1
    logic clr_cnt;   // entry count <= 0
    logic rd_prev;   // read store at pos-1
    logic wr_shift;  // store[pos] <= read data, pos--
    logic wr_item;   // store[pos] <= captured item
    logic dec_pos;   // pos--
    logic ld_out;    // output register <= read data
    logic ld_empty;  // output register <= empty marker
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic is_end;
    logic is_live;
    logic cnt_zero;
    logic not_full;
    logic pos_zero;
    logic pos_le1;
    logic better;
  } dp_stat_t;

  // Strict ranking: key first, then smaller id
  function automatic logic ranks_better(entry_t a, entry_t b, logic asc);
    logic res;
    if (a.val != b.val) begin
      res = asc ? (a.val < b.val) : (a.val > b.val);
    end else begin
      res = (a.id < b.id);
    end
    return res;
  endfunction

endpackage

// ----- rtl/tksel_ram.sv -----
module tksel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                               wdata,
  input  logic                                           re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/tksel_dpath.sv -----
module tksel_dpath
  import tksel_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_data,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output out_item_t             out_data
);

  logic              ascending_r;
  logic [KEEP_W-1:0] keep_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  in_item_t          item_r;
  out_item_t         out_r;

  entry_t            item_entry;
  entry_t            rd_entry;
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] wr_data;
  logic [CNT_W-1:0]  pos_m1;
  logic [CAP_W-1:0]  keep_ext, depth_ext, cap;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ascending_r <= 1'b1;
      keep_r      <= KEEP_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ASCENDING:  ascending_r <= cfg_data[0];
        CFG_KEEP_COUNT: keep_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Entry count and insert/drain position
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clr_cnt) begin
      cnt_nxt = '0;
    end else if (cmd.inc_cnt) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    pos_nxt = pos_r;
    if (cmd.set_pos) begin
      pos_nxt = cnt_r;
    end else if (cmd.wr_shift || cmd.dec_pos) begin
      pos_nxt = pos_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pos_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
    end
  end

  // Captured input item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
    end
  end

  assign pos_m1          = pos_r - 1'b1;
  assign item_entry.id   = item_r.doc_id;
  assign item_entry.val  = item_r.sort_value;
  assign rd_entry        = entry_t'(rd_data);
  assign wr_data         = cmd.wr_shift ? rd_data : ENTRY_W'(item_entry);

  // Entry store
  tksel_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_shift | cmd.wr_item),
    .waddr (pos_r[ADDR_W-1:0]),
    .wdata (wr_data),
    .re    (cmd.rd_prev),
    .raddr (pos_m1[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  // Capacity: keep_count saturated to the store depth
  assign keep_ext  = CAP_W'(keep_r);
  assign depth_ext = CAP_W'(STORE_DEPTH);
  assign cap       = (keep_ext > depth_ext) ? depth_ext : keep_ext;

  // Status
  always_comb begin
    stat.is_end   = (item_r.kind == KIND_END);
    stat.is_live  = item_r.live;
    stat.cnt_zero = (cnt_r == '0);
    stat.not_full = (CAP_W'(cnt_r) < cap);
    stat.pos_zero = (pos_r == '0);
    stat.pos_le1  = (pos_r <= CNT_W'(1));
    stat.better   = ranks_better(item_entry, rd_entry, ascending_r);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_r.out_doc_id <= rd_entry.id;
      out_r.out_value  <= rd_entry.val;
      out_r.valid_res  <= 1'b1;
      out_r.last       <= (pos_r == CNT_W'(1));
    end else if (cmd.ld_empty) begin
      out_r.out_doc_id <= '0;
      out_r.out_value  <= '0;
      out_r.valid_res  <= 1'b0;
      out_r.last       <= 1'b1;
    end
  end

  assign out_data = out_r;

endmodule

// ----- rtl/tksel_ctrl.sv -----
module tksel_ctrl
  import tksel_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_DECIDE  = 7'b0000010,
    S_CHECK   = 7'b0000100,
    S_CMP     = 7'b0001000,
    S_DR_READ = 7'b0010000,
    S_DR_LOAD = 7'b0100000,
    S_DR_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   gate_r, gate_nxt;

  // gate: comparing against the worst entry of a full store, no write yet
  always_comb begin
    state_nxt = state_r;
    gate_nxt  = gate_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_end) begin
          cmd.set_pos = 1'b1;
          if (stat.cnt_zero) begin
            cmd.ld_empty = 1'b1;
            state_nxt    = S_DR_OUT;
          end else begin
            state_nxt = S_DR_READ;
          end
        end else if (!stat.is_live) begin
          state_nxt = S_IDLE;
        end else if (stat.not_full) begin
          cmd.set_pos = 1'b1;
          cmd.inc_cnt = 1'b1;
          gate_nxt    = 1'b0;
          state_nxt   = S_CHECK;
        end else if (stat.cnt_zero) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.set_pos = 1'b1;
          gate_nxt    = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.pos_zero) begin
          cmd.wr_item = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_nxt   = S_CMP;
        end
      end
      S_CMP: begin
        if (gate_r) begin
          if (stat.better) begin
            cmd.dec_pos = 1'b1;
            gate_nxt    = 1'b0;
            state_nxt   = S_CHECK;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (stat.better) begin
          cmd.wr_shift = 1'b1;
          state_nxt    = S_CHECK;
        end else begin
          cmd.wr_item = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_DR_READ: begin
        cmd.rd_prev = 1'b1;
        state_nxt   = S_DR_LOAD;
      end
      S_DR_LOAD: begin
        cmd.ld_out = 1'b1;
        state_nxt  = S_DR_OUT;
      end
      S_DR_OUT: begin
        if (out_ready) begin
          if (stat.pos_le1) begin
            cmd.clr_cnt = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            cmd.dec_pos = 1'b1;
            state_nxt   = S_DR_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gate_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      gate_r  <= gate_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DR_OUT);

endmodule

// ----- rtl/top_k_sorted_result_selector.sv -----
// Channel   Direction  Handshake                  Payload
// in_       input      in_valid / in_ready        in_item_t (kind, doc_id, sort_value, live)
// out_      output     out_valid / out_ready      out_item_t (out_doc_id, out_value,
//                                                             valid_res, last)
// cfg_      input      cfg_we (no wait)           cfg_index, cfg_data
//
// One transaction at a time, accepted only when idle. A candidate is decoded, then dropped,
// or compared against the worst entry of a full store and dropped when it loses; a kept one
// is written after a position check, first displacing the worst entry of a full store when
// it beats it, and each entry it moves past costs a store read, then a compare.
// An end item is decoded, then each result takes a store read, an output load and the
// wait for out_ready; an empty store loads its single empty-marker result at decode.
// Reset (rst_n low, synchronous) empties the store and restores ascending=1, keep=16.
// A stall on out_ready holds the result and blocks new input transactions.
module top_k_sorted_result_selector
  import tksel_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  tksel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Store, compare and output register
  tksel_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/tksel_chk.sv -----
module tksel_chk
  import tksel_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // No input transaction while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // Empty-store marker is always the last result
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |-> out_data.last)
    else $error("empty result without last");

  // A drain continues after a non-final result
  a_drain_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=> !in_ready)
    else $error("drain ended before last");

  // Each accepted item is decoded before the next
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("back-to-back input accepted");

endmodule

bind top_k_sorted_result_selector tksel_chk u_tksel_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
